// ----- hw/rtl/pnit_pkg.sv -----
// Package for the path nearest-index tracker.
// Shared types, codes and arithmetic constants; no dependencies.
package pnit_pkg;

  localparam int COORD_BITS   = 24;
  localparam int PATH_POINTS_DEF = 4096;
  localparam int INDEX_BITS   = 12;
  localparam int STATUS_BITS  = 2;
  localparam int OP_BITS      = 2;
  localparam int WIDTH_BITS   = 20;
  localparam int CFG_IDX_BITS = 1;

  // Axis differences clamp to 22 bits; three squares sum into 46 bits.
  localparam int CLAMP_BITS = 22;
  localparam int SQ_BITS    = 2 * CLAMP_BITS;
  localparam int DIST_BITS  = SQ_BITS + 2;
  localparam logic [CLAMP_BITS-1:0] AXIS_CLAMP = {CLAMP_BITS{1'b1}};

  // (100 m in Q.10) squared
  localparam logic [DIST_BITS-1:0] BEST_INIT = DIST_BITS'(64'd10485760000);

  localparam logic [WIDTH_BITS-1:0] SEARCH_WIDTH_RST = WIDTH_BITS'(2048);

  // opcodes
  localparam logic [OP_BITS-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_BITS-1:0] OP_POSE   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_STORED  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_POSE_OK = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd3;

  // config register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_MODE  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEARCH_WIDTH = 1'd1;

  typedef struct packed {
    logic [OP_BITS-1:0]           opcode;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]  path_index;
    logic [STATUS_BITS-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_W_GO,
    S_W_WAIT,
    S_WALK_RD,
    S_WALK_GO,
    S_WALK_WAIT,
    S_WIN,
    S_SCAN_RD,
    S_SCAN_GO,
    S_SCAN_WAIT,
    S_RESP
  } state_t;

endpackage

// ----- hw/rtl/pnit_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pnit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pnit_dist.sv -----
// Shared squared-distance unit: one axis per step through a single squarer.
// Depends on pnit_pkg (point_t, clamp and width constants).
module pnit_dist (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  pnit_pkg::point_t                a,
  input  pnit_pkg::point_t                b,
  output logic                            done,
  output logic [pnit_pkg::DIST_BITS-1:0]  dist_sq
);

  localparam int CB = pnit_pkg::COORD_BITS;

  pnit_pkg::point_t a_r, b_r;
  logic [2:0] ph_r;
  logic       busy_r;
  logic       done_r;
  logic [pnit_pkg::CLAMP_BITS-1:0] d_r;
  logic [pnit_pkg::SQ_BITS-1:0]    sq_r;
  logic [pnit_pkg::DIST_BITS-1:0]  acc_r;

  logic signed [CB-1:0] ea, eb;
  logic signed [CB:0]   diff;
  logic [CB:0]          mag;
  logic [pnit_pkg::CLAMP_BITS-1:0] d_clamp;

  // axis select, abs difference, clamp
  always_comb begin
    case (ph_r)
      3'd0: begin
        ea = a_r.x;
        eb = b_r.x;
      end
      3'd1: begin
        ea = a_r.y;
        eb = b_r.y;
      end
      default: begin
        ea = a_r.z;
        eb = b_r.z;
      end
    endcase
    diff = {ea[CB-1], ea} - {eb[CB-1], eb};
    mag  = diff[CB] ? $unsigned(-diff) : $unsigned(diff);
    if (mag > (CB+1)'(pnit_pkg::AXIS_CLAMP)) begin
      d_clamp = pnit_pkg::AXIS_CLAMP;
    end else begin
      d_clamp = mag[pnit_pkg::CLAMP_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        ph_r <= ph_r + 3'd1;
        if (ph_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // three-stage flow: diff -> square -> accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (ph_r inside {[3'd0:3'd2]}) begin
        d_r <= d_clamp;
      end
      if (ph_r inside {[3'd1:3'd3]}) begin
        sq_r <= d_r * d_r;
      end
      if (ph_r inside {[3'd2:3'd4]}) begin
        acc_r <= acc_r + pnit_pkg::DIST_BITS'(sq_r);
      end
    end
  end

  assign done    = done_r;
  assign dist_sq = acc_r;

endmodule

// ----- hw/rtl/path_nearest_index_tracker_top.sv -----
// Path nearest-index tracker, top level. Uses pnit_pkg, pnit_ram, pnit_dist.
// Append, clear, teach pose and empty-path pose: result is valid in the cycle after transfer.
// Repeat pose: the width is squared first, then each visited walk or window point
//   costs a RAM read plus one pass of the shared squared-distance unit (3 axes).
// One item at a time: in_stall is high from transfer until the result is taken.
// Reset (sync, rst_n low): empty path, index 0, teach mode, width 2 m; RAM not cleared.
module path_nearest_index_tracker_top #(
  parameter int PATH_POINTS = pnit_pkg::PATH_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pnit_pkg::in_item_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output pnit_pkg::out_item_t                 out_data,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [pnit_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pnit_pkg::WIDTH_BITS-1:0]     cfg_wdata
);

  localparam int AW = $clog2(PATH_POINTS);        // point address
  localparam int CW = $clog2(PATH_POINTS + 1);    // point count
  localparam int LW = CW + 1;                     // window low-bound math
  localparam int IW = (AW > pnit_pkg::INDEX_BITS) ? AW : pnit_pkg::INDEX_BITS;
  localparam int DB = pnit_pkg::DIST_BITS;

  pnit_pkg::state_t state_r, state_nxt;

  // architectural state
  logic [CW-1:0] count_r;
  logic [AW-1:0] cur_r;
  logic          repeat_r;
  logic [pnit_pkg::WIDTH_BITS-1:0]  width_r;
  logic [pnit_pkg::STATUS_BITS-1:0] status_r;

  // search working registers
  pnit_pkg::point_t pose_r, ref_r;
  logic [AW-1:0] c_r;       // clamped current point
  logic [CW-1:0] j_r;       // cur + half, ends as window high bound
  logic [CW-1:0] s_r;       // scan pointer
  logic [AW-1:0] pick_r;
  logic [DB-1:0] best_r;
  logic [DB-1:0] w2_r;

  // RAM and distance unit hookup
  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  pnit_pkg::point_t ram_wdata, ram_rdata;
  logic             dist_start;
  pnit_pkg::point_t dist_a, dist_b;
  logic             dist_done;
  logic [DB-1:0]    dist_val;

  logic          accept;
  logic          not_full;
  logic [AW-1:0] c_clamp;
  logic [LW-1:0] c2, jw, lo_w;
  logic [IW-1:0] cur_ext;

  assign accept   = in_valid && (state_r == pnit_pkg::S_IDLE);
  assign not_full = (count_r < CW'(PATH_POINTS));

  // index past the path end searches from the last stored point
  assign c_clamp = (CW'(cur_r) >= count_r) ? AW'(count_r - CW'(1)) : cur_r;

  // window low bound: max(0, cur - half) with half = j - cur
  assign c2   = LW'(c_r) << 1;
  assign jw   = LW'(j_r);
  assign lo_w = (c2 < jw) ? '0 : (c2 - jw);

  assign ram_wdata = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
  assign ram_we    = accept && (in_data.opcode == pnit_pkg::OP_APPEND) && not_full;

  pnit_ram #(
    .WIDTH ($bits(pnit_pkg::point_t)),
    .DEPTH (PATH_POINTS)
  ) u_path_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pnit_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dist_start),
    .a       (dist_a),
    .b       (dist_b),
    .done    (dist_done),
    .dist_sq (dist_val)
  );

  // sequencer: next state, RAM address, distance operands
  always_comb begin
    state_nxt  = state_r;
    ram_raddr  = c_r;
    dist_start = 1'b0;
    dist_a     = ref_r;
    dist_b     = ram_rdata;
    case (state_r)
      pnit_pkg::S_IDLE: begin
        if (accept) begin
          if ((in_data.opcode == pnit_pkg::OP_POSE) && repeat_r && (count_r != '0)) begin
            state_nxt = pnit_pkg::S_W_GO;
          end else begin
            state_nxt = pnit_pkg::S_RESP;
          end
        end
      end
      pnit_pkg::S_W_GO: begin
        // width squared through the same unit: (w,0,0) against the origin
        dist_start = 1'b1;
        dist_a     = '{x: pnit_pkg::COORD_BITS'(width_r), y: '0, z: '0};
        dist_b     = '0;
        state_nxt  = pnit_pkg::S_W_WAIT;
      end
      pnit_pkg::S_W_WAIT: begin
        if (dist_done) begin
          state_nxt = pnit_pkg::S_WALK_RD;
        end
      end
      pnit_pkg::S_WALK_RD: begin
        ram_raddr = j_r[AW-1:0];
        if (j_r < count_r) begin
          state_nxt = pnit_pkg::S_WALK_GO;
        end else begin
          state_nxt = pnit_pkg::S_WIN;
        end
      end
      pnit_pkg::S_WALK_GO: begin
        ram_raddr  = j_r[AW-1:0];
        dist_start = 1'b1;
        state_nxt  = pnit_pkg::S_WALK_WAIT;
      end
      pnit_pkg::S_WALK_WAIT: begin
        if (dist_done) begin
          if (dist_val < w2_r) begin
            state_nxt = pnit_pkg::S_WALK_RD;
          end else begin
            state_nxt = pnit_pkg::S_WIN;
          end
        end
      end
      pnit_pkg::S_WIN: begin
        state_nxt = pnit_pkg::S_SCAN_RD;
      end
      pnit_pkg::S_SCAN_RD: begin
        ram_raddr = s_r[AW-1:0];
        if (s_r < j_r) begin
          state_nxt = pnit_pkg::S_SCAN_GO;
        end else begin
          state_nxt = pnit_pkg::S_RESP;
        end
      end
      pnit_pkg::S_SCAN_GO: begin
        ram_raddr  = s_r[AW-1:0];
        dist_start = 1'b1;
        dist_a     = pose_r;
        state_nxt  = pnit_pkg::S_SCAN_WAIT;
      end
      pnit_pkg::S_SCAN_WAIT: begin
        if (dist_done) begin
          state_nxt = pnit_pkg::S_SCAN_RD;
        end
      end
      pnit_pkg::S_RESP: begin
        if (!out_stall) begin
          state_nxt = pnit_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pnit_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pnit_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_r <= 1'b0;
      width_r  <= pnit_pkg::SEARCH_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pnit_pkg::CFG_REPEAT_MODE:  repeat_r <= cfg_wdata[0];
        pnit_pkg::CFG_SEARCH_WIDTH: width_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // path count and current index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cur_r   <= '0;
    end else begin
      if (accept) begin
        case (in_data.opcode)
          pnit_pkg::OP_APPEND: begin
            if (not_full) begin
              count_r <= count_r + CW'(1);
            end
          end
          pnit_pkg::OP_POSE: begin
            // teach mode: advance, saturating at the last slot
            if (!repeat_r && (cur_r < AW'(PATH_POINTS - 1))) begin
              cur_r <= cur_r + AW'(1);
            end
          end
          pnit_pkg::OP_CLEAR: begin
            count_r <= '0;
            cur_r   <= '0;
          end
          default: ;
        endcase
      end else if ((state_r == pnit_pkg::S_SCAN_RD) && !(s_r < j_r)) begin
        cur_r <= pick_r;
      end
    end
  end

  // status and search datapath (payload, no reset)
  always_ff @(posedge clk) begin
    case (state_r)
      pnit_pkg::S_IDLE: begin
        if (accept) begin
          c_r    <= c_clamp;
          pick_r <= c_clamp;
          j_r    <= CW'(c_clamp);
          best_r <= pnit_pkg::BEST_INIT;
          pose_r <= ram_wdata;
          case (in_data.opcode)
            pnit_pkg::OP_APPEND: begin
              status_r <= not_full ? pnit_pkg::ST_STORED : pnit_pkg::ST_FULL;
            end
            pnit_pkg::OP_POSE: begin
              if (repeat_r && (count_r == '0)) begin
                status_r <= pnit_pkg::ST_EMPTY;
              end else begin
                status_r <= pnit_pkg::ST_POSE_OK;
              end
            end
            default: status_r <= pnit_pkg::ST_STORED;
          endcase
        end
      end
      pnit_pkg::S_W_WAIT: begin
        if (dist_done) begin
          w2_r  <= dist_val;
          ref_r <= ram_rdata;   // read address held at the clamped point
        end
      end
      pnit_pkg::S_WALK_WAIT: begin
        if (dist_done && (dist_val < w2_r)) begin
          j_r <= j_r + CW'(1);
        end
      end
      pnit_pkg::S_WIN: begin
        s_r <= CW'(lo_w);
      end
      pnit_pkg::S_SCAN_WAIT: begin
        if (dist_done) begin
          if (dist_val < best_r) begin
            best_r <= dist_val;
            pick_r <= s_r[AW-1:0];
          end
          s_r <= s_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // result outputs: index is read straight from the held state
  assign cur_ext   = IW'(cur_r);
  assign out_valid = (state_r == pnit_pkg::S_RESP);
  assign out_data  = '{path_index: cur_ext[pnit_pkg::INDEX_BITS-1:0], status: status_r};
  assign in_stall  = (state_r != pnit_pkg::S_IDLE);

endmodule
